// ===== rtl/tpt_pkg.sv =====
// Shared types, constants and helpers for the TLB page table translator.
// Used by tpt_ptab, tpt_cell and tlb_page_table_translator; depends on nothing.
`default_nettype none

package tpt_pkg;

	localparam int TLB_ENTRIES_DEF = 16;
	localparam int PAGE_COUNT_DEF  = 256;
	localparam int OFFSET_BITS_DEF = 8;

	localparam int VA_W = 16;
	localparam int PA_W = 16;

	localparam int AGE_W = 16;
	localparam logic [AGE_W-1:0] AGE_RESET = 16'd10000;
	localparam logic [AGE_W-1:0] AGE_MAX   = 16'hFFFF;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SEARCH
	} state_t;

	typedef struct packed {
		logic touch;
		logic load;
		logic zero_age;
		logic age_rest;
	} cell_cmd_t;

	function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
		age_up = (a == AGE_MAX) ? a : a + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tpt_ptab.sv =====
// Page table memory: one {present, frame} word per page, registered read.
// Sweeps every word to not-present after reset; uses tpt_pkg defaults.
`default_nettype none

module tpt_ptab #(
	parameter int PAGE_COUNT = tpt_pkg::PAGE_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rd_en,
	input  wire logic [$clog2(PAGE_COUNT)-1:0]  rd_addr,
	output logic      [$clog2(PAGE_COUNT):0]    rd_data,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(PAGE_COUNT)-1:0]  wr_addr,
	input  wire logic [$clog2(PAGE_COUNT):0]    wr_data,
	output logic                                ready
);

	localparam int PAGE_BITS = $clog2(PAGE_COUNT);

	logic [PAGE_BITS:0]   mem [PAGE_COUNT];
	logic [PAGE_BITS:0]   rd_data_q;
	logic                 clr_active_q;
	logic [PAGE_BITS-1:0] clr_addr_q;
	logic                 we;
	logic [PAGE_BITS-1:0] waddr;
	logic [PAGE_BITS:0]   wdata;

	always_comb begin
		if (clr_active_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = wr_en;
			waddr = wr_addr;
			wdata = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == PAGE_BITS'(PAGE_COUNT - 1))
				clr_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign ready   = !clr_active_q;

endmodule

`default_nettype wire

// ===== rtl/tpt_cell.sv =====
// One TLB entry: tag, frame, valid and age, plus one stage of the oldest-entry search chain.
// Uses tpt_pkg for the command struct, age width and age helper.
`default_nettype none

module tpt_cell #(
	parameter int PAGE_BITS = $clog2(tpt_pkg::PAGE_COUNT_DEF),
	parameter int IDX_W     = $clog2(tpt_pkg::TLB_ENTRIES_DEF),
	parameter int CELL_IDX  = 0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tpt_pkg::cell_cmd_t           cmd,
	input  wire logic [IDX_W-1:0]             load_idx,
	input  wire logic [PAGE_BITS-1:0]         lookup_page,
	input  wire logic [PAGE_BITS-1:0]         load_frame,
	output logic                              match,
	output logic      [PAGE_BITS-1:0]         frame,
	input  wire logic                         srch_vld_i,
	input  wire logic [tpt_pkg::AGE_W-1:0]    srch_age_i,
	input  wire logic [IDX_W-1:0]             srch_idx_i,
	output logic                              srch_vld_o,
	output logic      [tpt_pkg::AGE_W-1:0]    srch_age_o,
	output logic      [IDX_W-1:0]             srch_idx_o
);

	logic [PAGE_BITS-1:0]      tag_q;
	logic [PAGE_BITS-1:0]      frame_q;
	logic                      valid_q;
	logic [tpt_pkg::AGE_W-1:0] age_q;
	logic [tpt_pkg::AGE_W-1:0] age_d;
	logic                      srch_vld_q;
	logic [tpt_pkg::AGE_W-1:0] srch_age_q;
	logic [IDX_W-1:0]          srch_idx_q;
	logic                      sel;

	assign sel   = (load_idx == IDX_W'(CELL_IDX));
	assign match = valid_q && (tag_q == lookup_page);
	assign frame = frame_q;

	always_comb begin
		age_d = age_q;
		if (cmd.touch)
			age_d = match ? '0 : tpt_pkg::age_up(age_q);
		if (cmd.age_rest && !sel)
			age_d = tpt_pkg::age_up(age_q);
		if (cmd.load && cmd.zero_age && sel)
			age_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			age_q      <= tpt_pkg::AGE_RESET;
			srch_vld_q <= 1'b0;
		end else begin
			age_q      <= age_d;
			srch_vld_q <= srch_vld_i;
			if (cmd.load && sel)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && sel) begin
			tag_q   <= lookup_page;
			frame_q <= load_frame;
		end
		if (age_q > srch_age_i) begin
			srch_age_q <= age_q;
			srch_idx_q <= IDX_W'(CELL_IDX);
		end else begin
			srch_age_q <= srch_age_i;
			srch_idx_q <= srch_idx_i;
		end
	end

	assign srch_vld_o = srch_vld_q;
	assign srch_age_o = srch_age_q;
	assign srch_idx_o = srch_idx_q;

endmodule

`default_nettype wire

// ===== rtl/tlb_page_table_translator.sv =====
// Virtual to physical translation: a row of TLB cells in front of a page table memory.
// The result strobe is registered from the lookup state that follows the start beat; the
// receiver cannot stall. Hits, and faults and misses in FIFO mode, go from lookup back to
// idle; faults and misses in LRU mode first wait on the age search chain, which runs one
// cell per cycle. A new address is taken only in idle. After reset busy stays high while
// the page table is swept to not-present. Uses tpt_pkg, tpt_ptab and tpt_cell.
`default_nettype none

module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
	parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
	parameter int OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [tpt_pkg::VA_W-1:0]   virtual_address,
	output logic                            done,
	output logic      [tpt_pkg::PA_W-1:0]   physical_address,
	output logic                            tlb_hit,
	output logic                            page_fault,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       cfg_data
);

	localparam int PAGE_BITS = $clog2(PAGE_COUNT);
	localparam int IDX_W     = $clog2(TLB_ENTRIES);
	localparam int PA_FULL_W = PAGE_BITS + OFFSET_BITS;

	tpt_pkg::state_t    state_q, state_d;
	tpt_pkg::cell_cmd_t cmd;

	logic                      policy_q;
	logic [PAGE_BITS-1:0]      page_q;
	logic [OFFSET_BITS-1:0]    offset_q;
	logic [PAGE_BITS-1:0]      frame_q;
	logic                      lru_fault_q;
	logic                      launch_q;
	logic [IDX_W-1:0]          fifo_ptr_q;
	logic [PAGE_BITS:0]        nff_q;
	logic                      done_q;
	logic [tpt_pkg::PA_W-1:0]  pa_q;
	logic                      hit_q;
	logic                      fault_q;

	logic                      accept;
	logic [tpt_pkg::VA_W-1:0]  va_shift;
	logic [PAGE_BITS-1:0]      in_page;
	logic                      pt_ready;
	logic [PAGE_BITS:0]        pt_rd_data;
	logic                      pt_we;
	logic                      present;
	logic                      any_match;
	logic                      hit;
	logic [PAGE_BITS-1:0]      tlb_frame;
	logic [PAGE_BITS-1:0]      frame_now;
	logic [PAGE_BITS-1:0]      load_frame;
	logic [IDX_W-1:0]          load_idx;
	logic                      look_done;
	logic                      launch_d;
	logic                      fifo_adv;
	logic [PA_FULL_W-1:0]      pa_full;

	logic                      match_w [TLB_ENTRIES];
	logic [PAGE_BITS-1:0]      frame_w [TLB_ENTRIES];
	logic                      srch_vld [TLB_ENTRIES+1];
	logic [tpt_pkg::AGE_W-1:0] srch_age [TLB_ENTRIES+1];
	logic [IDX_W-1:0]          srch_idx [TLB_ENTRIES+1];

	assign busy      = (state_q != tpt_pkg::ST_IDLE) || !pt_ready;
	assign accept    = start && !busy;
	assign va_shift  = virtual_address >> OFFSET_BITS;
	assign in_page   = va_shift[PAGE_BITS-1:0];
	assign cfg_ready = 1'b1;

	tpt_ptab #(
		.PAGE_COUNT(PAGE_COUNT)
	) u_ptab (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_page),
		.rd_data (pt_rd_data),
		.wr_en   (pt_we),
		.wr_addr (page_q),
		.wr_data ({1'b1, frame_now}),
		.ready   (pt_ready)
	);

	assign srch_vld[0] = launch_q;
	assign srch_age[0] = '0;
	assign srch_idx[0] = '0;

	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		tpt_cell #(
			.PAGE_BITS (PAGE_BITS),
			.IDX_W     (IDX_W),
			.CELL_IDX  (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.load_idx    (load_idx),
			.lookup_page (page_q),
			.load_frame  (load_frame),
			.match       (match_w[i]),
			.frame       (frame_w[i]),
			.srch_vld_i  (srch_vld[i]),
			.srch_age_i  (srch_age[i]),
			.srch_idx_i  (srch_idx[i]),
			.srch_vld_o  (srch_vld[i+1]),
			.srch_age_o  (srch_age[i+1]),
			.srch_idx_o  (srch_idx[i+1])
		);
	end

	always_comb begin
		any_match = 1'b0;
		tlb_frame = '0;
		for (int k = 0; k < TLB_ENTRIES; k++) begin
			any_match = any_match | match_w[k];
			tlb_frame = tlb_frame | (match_w[k] ? frame_w[k] : '0);
		end
	end

	assign present = pt_rd_data[PAGE_BITS];
	assign hit     = present && any_match;

	always_comb begin
		if (!present)
			frame_now = nff_q[PAGE_BITS-1:0];
		else if (hit)
			frame_now = tlb_frame;
		else
			frame_now = pt_rd_data[PAGE_BITS-1:0];
	end

	assign pa_full = {frame_now, offset_q};

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		load_idx   = fifo_ptr_q;
		load_frame = frame_now;
		pt_we      = 1'b0;
		look_done  = 1'b0;
		launch_d   = 1'b0;
		fifo_adv   = 1'b0;
		unique case (state_q)
			tpt_pkg::ST_IDLE: begin
				if (accept)
					state_d = tpt_pkg::ST_LOOK;
			end
			tpt_pkg::ST_LOOK: begin
				look_done = 1'b1;
				cmd.touch = present;
				pt_we     = !present;
				state_d   = tpt_pkg::ST_IDLE;
				if (!hit) begin
					if (policy_q == tpt_pkg::POLICY_FIFO) begin
						cmd.load = 1'b1;
						fifo_adv = 1'b1;
					end else begin
						launch_d = 1'b1;
						state_d  = tpt_pkg::ST_SEARCH;
					end
				end
			end
			tpt_pkg::ST_SEARCH: begin
				load_idx   = srch_idx[TLB_ENTRIES];
				load_frame = frame_q;
				if (srch_vld[TLB_ENTRIES]) begin
					cmd.load     = 1'b1;
					cmd.zero_age = 1'b1;
					cmd.age_rest = lru_fault_q;
					state_d      = tpt_pkg::ST_IDLE;
				end
			end
			default: state_d = tpt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tpt_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= tpt_pkg::POLICY_FIFO;
			fifo_ptr_q <= '0;
			nff_q      <= '0;
			launch_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			launch_q <= launch_d;
			done_q   <= look_done;
			if (cfg_valid && cfg_ready)
				policy_q <= cfg_data;
			if (fifo_adv)
				fifo_ptr_q <= (fifo_ptr_q == IDX_W'(TLB_ENTRIES - 1)) ? '0 : fifo_ptr_q + 1'b1;
			if (pt_we && (nff_q < (PAGE_BITS+1)'(PAGE_COUNT)))
				nff_q <= nff_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q   <= in_page;
			offset_q <= virtual_address[OFFSET_BITS-1:0];
		end
		if (look_done) begin
			frame_q     <= frame_now;
			lru_fault_q <= !present;
			pa_q        <= tpt_pkg::PA_W'(pa_full);
			hit_q       <= hit;
			fault_q     <= !present;
		end
	end

	assign done             = done_q;
	assign physical_address = pa_q;
	assign tlb_hit          = hit_q;
	assign page_fault       = fault_q;

`ifndef NO_ASSERTIONS
	a_done_after_look: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == tpt_pkg::ST_LOOK))
		else $error("result beat without a lookup cycle");

	a_fault_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tpt_pkg::ST_LOOK) && !present) |-> !any_match)
		else $error("absent page held in the TLB");

	a_hit_not_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(hit_q && fault_q))
		else $error("result marked both hit and fault");

	a_nff_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nff_q <= (PAGE_BITS+1)'(PAGE_COUNT))
		else $error("free frame counter past page count");

	a_fifo_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_ptr_q <= IDX_W'(TLB_ENTRIES - 1))
		else $error("fifo pointer past last entry");

	a_search_exits: assert property (@(posedge clk) disable iff (!arst_n)
		srch_vld[TLB_ENTRIES] |-> (state_q == tpt_pkg::ST_SEARCH) ##1 (state_q == tpt_pkg::ST_IDLE))
		else $error("search result arrived outside the search state");
`endif

endmodule

`default_nettype wire
